FILE: src/weighted_automaton_cell_update_defines.svh
// assertion macros used by the checker file
`ifndef WEIGHTED_AUTOMATON_CELL_UPDATE_DEFINES_SVH
`define WEIGHTED_AUTOMATON_CELL_UPDATE_DEFINES_SVH

// checked only outside reset
`define WACU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every edge, reset included
`define WACU_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: src/wacu_pkg.sv
package wacu_pkg;

  localparam int WEIGHT_W    = 16;
  localparam int SUM_W       = 20;
  localparam int TEMP_W      = 16;
  localparam int NB_W        = 8;
  localparam int KREG_W      = 48;
  localparam int RULE_W      = 19;
  localparam int RULE_SLOTS  = 3;
  localparam int RTAB_W      = RULE_W * RULE_SLOTS;
  localparam int RCNT_W      = 2;
  localparam int CODE_W      = 3;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = RTAB_W;
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 24;

  localparam logic signed [TEMP_W-1:0] TEMP_LIMIT_RESET = 16'sd8000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KERNEL_LOW  = 3'd0,
    CFG_KERNEL_MID  = 3'd1,
    CFG_KERNEL_HIGH = 3'd2,
    CFG_RULE_TABLE  = 3'd3,
    CFG_RULE_COUNT  = 3'd4,
    CFG_TEMP_LIMIT  = 3'd5
  } cfg_index_t;

  typedef enum logic [CODE_W-1:0] {
    CMP_LT = 3'd0,
    CMP_LE = 3'd1,
    CMP_EQ = 3'd2,
    CMP_GE = 3'd3,
    CMP_GT = 3'd4
  } cmp_code_t;

  typedef enum logic [1:0] {
    STATUS_IDLE   = 2'd0,
    STATUS_ACTIVE = 2'd1,
    STATUS_ERROR  = 2'd2
  } node_status_t;

  typedef struct packed {
    logic [KREG_W-1:0]        kernel_high;
    logic [KREG_W-1:0]        kernel_mid;
    logic [KREG_W-1:0]        kernel_low;
    logic [RTAB_W-1:0]        rule_table;
    logic [RCNT_W-1:0]        rule_count;
    logic signed [TEMP_W-1:0] temp_limit;
  } cfg_t;

endpackage

FILE: src/wacu_cfg_regs.sv
module wacu_cfg_regs (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [wacu_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [wacu_pkg::CFG_DATA_W-1:0]   cfg_data,
  output wacu_pkg::cfg_t                    cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.kernel_low  <= '0;
      cfg.kernel_mid  <= '0;
      cfg.kernel_high <= '0;
      cfg.rule_table  <= '0;
      cfg.rule_count  <= '0;
      cfg.temp_limit  <= wacu_pkg::TEMP_LIMIT_RESET;
    end else if (cfg_valid) begin
      unique case (wacu_pkg::cfg_index_t'(cfg_index))
        wacu_pkg::CFG_KERNEL_LOW:  cfg.kernel_low  <= cfg_data[wacu_pkg::KREG_W-1:0];
        wacu_pkg::CFG_KERNEL_MID:  cfg.kernel_mid  <= cfg_data[wacu_pkg::KREG_W-1:0];
        wacu_pkg::CFG_KERNEL_HIGH: cfg.kernel_high <= cfg_data[wacu_pkg::KREG_W-1:0];
        wacu_pkg::CFG_RULE_TABLE:  cfg.rule_table  <= cfg_data[wacu_pkg::RTAB_W-1:0];
        wacu_pkg::CFG_RULE_COUNT:  cfg.rule_count  <= cfg_data[wacu_pkg::RCNT_W-1:0];
        wacu_pkg::CFG_TEMP_LIMIT:  cfg.temp_limit  <= cfg_data[wacu_pkg::TEMP_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

FILE: src/wacu_datapath.sv
module wacu_datapath #(
  parameter int KERNEL_TAPS = 9,
  parameter int MAX_RULES   = 3
) (
  input  wacu_pkg::cfg_t                          cfg,
  input  logic [wacu_pkg::NB_W-1:0]               neighbours,
  input  logic                                    presence,
  input  logic signed [wacu_pkg::TEMP_W-1:0]      temperature,
  input  logic                                    cell_value,
  output logic                                    new_value,
  output logic [1:0]                              node_status,
  output logic signed [wacu_pkg::SUM_W-1:0]       weighted_sum
);

  localparam int WW = wacu_pkg::WEIGHT_W;
  localparam int SW = wacu_pkg::SUM_W;

  logic [3*wacu_pkg::KREG_W-1:0] weights;
  logic [KERNEL_TAPS-1:0]        tap_on;
  logic signed [SW-1:0]          term [KERNEL_TAPS];
  logic [MAX_RULES-1:0]          rule_hit;
  logic [MAX_RULES-1:0]          rule_en;
  logic [wacu_pkg::RCNT_W-1:0]   count_eff;

  assign weights = {cfg.kernel_high, cfg.kernel_mid, cfg.kernel_low};

  // own value always drives the last tap; neighbour bits beyond it are dropped
  genvar t;
  generate
    for (t = 0; t < KERNEL_TAPS; t++) begin : g_tap
      if (t == KERNEL_TAPS - 1) begin : g_own
        assign tap_on[t] = cell_value;
      end else if (t == 0) begin : g_first
        assign tap_on[t] = neighbours[0] | presence;
      end else begin : g_nb
        assign tap_on[t] = neighbours[t];
      end
      assign term[t] = tap_on[t] ?
        {{(SW-WW){weights[WW*t+WW-1]}}, weights[WW*t +: WW]} : '0;
    end
  endgenerate

  always_comb begin
    weighted_sum = '0;
    for (int i = 0; i < KERNEL_TAPS; i++) begin
      weighted_sum = weighted_sum + term[i];
    end
  end

  assign count_eff = (cfg.rule_count > wacu_pkg::RCNT_W'(MAX_RULES)) ?
                     wacu_pkg::RCNT_W'(MAX_RULES) : cfg.rule_count;

  genvar k;
  generate
    for (k = 0; k < MAX_RULES; k++) begin : g_rule
      logic [wacu_pkg::CODE_W-1:0] code;
      logic signed [SW-1:0]        thr;
      assign code = cfg.rule_table[wacu_pkg::RULE_W*k +: wacu_pkg::CODE_W];
      assign thr  = {{(SW-WW){cfg.rule_table[wacu_pkg::RULE_W*k + wacu_pkg::CODE_W + WW - 1]}},
                     cfg.rule_table[wacu_pkg::RULE_W*k + wacu_pkg::CODE_W +: WW]};
      assign rule_en[k] = wacu_pkg::RCNT_W'(k) < count_eff;
      always_comb begin
        unique case (code)
          wacu_pkg::CMP_LT: rule_hit[k] = weighted_sum <  thr;
          wacu_pkg::CMP_LE: rule_hit[k] = weighted_sum <= thr;
          wacu_pkg::CMP_EQ: rule_hit[k] = weighted_sum == thr;
          wacu_pkg::CMP_GE: rule_hit[k] = weighted_sum >= thr;
          wacu_pkg::CMP_GT: rule_hit[k] = weighted_sum >  thr;
          default:          rule_hit[k] = 1'b0;
        endcase
      end
    end
  endgenerate

  // the new value is set if any enabled rule hits; with no rule enabled, by a positive sum
  assign new_value = (count_eff == '0) ? (weighted_sum > 0) : |(rule_hit & rule_en);

  assign node_status = (temperature > cfg.temp_limit) ? wacu_pkg::STATUS_ERROR :
                       (new_value ? wacu_pkg::STATUS_ACTIVE : wacu_pkg::STATUS_IDLE);

endmodule

FILE: src/weighted_automaton_cell_update.sv
// Weighted-sum automaton cell: each input beat is one generation tick. The
// beat lands in an input register, the kernel sum over the neighbour bits and
// the stored own value, the rule checks and the temperature check run in one
// combinational pass, and the result goes to an output register together with
// the new own value. One beat is taken every cycle unless the input stalls, and
// the own value is fed back through its register, so the tick rate is set by
// that single pass. The input side stalls only while a finished result waits
// at the output and the input register is full. Configuration writes are taken
// every cycle and belong to idle periods.
module weighted_automaton_cell_update #(
  parameter int KERNEL_TAPS = 9,
  parameter int MAX_RULES   = 3
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  // neighbours[7:0], presence[8], temperature[24:9], zero pad above
  input  logic [wacu_pkg::IN_TDATA_W-1:0]       s_axis_tdata,
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  // new_value[0], node_status[2:1], weighted_sum[22:3], zero pad above
  output logic [wacu_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [wacu_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [wacu_pkg::CFG_DATA_W-1:0]       cfg_data
);

  localparam int NBW = wacu_pkg::NB_W;
  localparam int TW  = wacu_pkg::TEMP_W;
  localparam int SW  = wacu_pkg::SUM_W;

  wacu_pkg::cfg_t cfg;

  logic                 in_valid;
  logic [NBW-1:0]       in_nb;
  logic                 in_presence;
  logic signed [TW-1:0] in_temp;
  logic                 advance;

  logic                 cell_value;
  logic                 calc_value;
  logic [1:0]           calc_status;
  logic signed [SW-1:0] calc_sum;

  logic                 out_valid;
  logic                 out_value;
  logic [1:0]           out_status;
  logic signed [SW-1:0] out_sum;

  wacu_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  assign advance       = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_nb       <= s_axis_tdata[NBW-1:0];
      in_presence <= s_axis_tdata[NBW];
      in_temp     <= s_axis_tdata[NBW+1 +: TW];
    end
  end

  wacu_datapath #(
    .KERNEL_TAPS (KERNEL_TAPS),
    .MAX_RULES   (MAX_RULES)
  ) u_dp (
    .cfg          (cfg),
    .neighbours   (in_nb),
    .presence     (in_presence),
    .temperature  (in_temp),
    .cell_value   (cell_value),
    .new_value    (calc_value),
    .node_status  (calc_status),
    .weighted_sum (calc_sum)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cell_value <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (advance) begin
        cell_value <= calc_value;
        out_valid  <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_value  <= calc_value;
      out_status <= calc_status;
      out_sum    <= calc_sum;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {{(wacu_pkg::OUT_TDATA_W-SW-3){1'b0}}, out_sum, out_status, out_value};

endmodule

FILE: src/wacu_checker.sv
`include "weighted_automaton_cell_update_defines.svh"

module wacu_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               s_axis_tready,
  input logic                               m_axis_tvalid,
  input logic                               m_axis_tready,
  input logic [wacu_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);

  `WACU_ASSERT_ALWAYS(a_reset_empties, rst |=> !m_axis_tvalid, "result valid after reset")

  `WACU_ASSERT(a_stall_holds, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")

  // input only backs up behind a result that is waiting
  `WACU_ASSERT(a_backpressure, !s_axis_tready |-> m_axis_tvalid && !m_axis_tready, "input stalled without output stall")

  // status follows the new value unless over temperature
  `WACU_ASSERT(a_status_value, m_axis_tvalid && m_axis_tdata[2:1] != wacu_pkg::STATUS_ERROR |-> m_axis_tdata[2:1] == {1'b0, m_axis_tdata[0]}, "status does not match value")

endmodule

bind weighted_automaton_cell_update wacu_checker u_wacu_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
